>>> sv/gci_pkg.sv
// Shared types and constants for the Gouraud color interpolator.
`timescale 1ns / 1ps

package gci_pkg;

    typedef enum logic [3:0] {
        CMD_LOAD       = 4'd0,
        CMD_LEFT_SETUP = 4'd1,
        CMD_RIGHT_SETUP= 4'd2,
        CMD_SWAP       = 4'd3,
        CMD_SPAN_SETUP = 4'd4,
        CMD_SHADE      = 4'd5,
        CMD_STEP_SPAN  = 4'd6,
        CMD_STEP_LEFT  = 4'd7,
        CMD_STEP_RIGHT = 4'd8
    } t_cmd;

    localparam int COLOR_W  = 32;
    localparam int CHAN_W   = 8;
    localparam int LEN_W    = 14;
    localparam int CNT_W    = 13;
    localparam int IN_W     = 4 + 2 + 3 * CHAN_W + 2 + 2 + LEN_W + CNT_W;
    // bound on span lengths and step counts
    localparam int MAX_SPAN = 4096;

    // Classified command as held in the queue between front and back.
    typedef struct packed {
        logic [3:0]          cmd;
        logic                load_ok;
        logic [1:0]          vi;
        logic [CHAN_W-1:0]   r;
        logic [CHAN_W-1:0]   g;
        logic [CHAN_W-1:0]   b;
        logic [1:0]          sv;
        logic [1:0]          ev;
        logic signed [LEN_W-1:0] len;
        logic [CNT_W-1:0]    cnt;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE,
        ST_STEP,
        ST_OUT
    } t_state;

endpackage

>>> sv/gci_front.sv
// Front end: accepts commands, clamps lengths and counts, selects vertices.
`timescale 1ns / 1ps

module gci_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [gci_pkg::IN_W-1:0] i_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output gci_pkg::t_item           o_item
);
    localparam int DEPTH = 2;

    gci_pkg::t_item r_q [DEPTH];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    gci_pkg::t_item w_item;

    logic [3:0]  w_cmd;
    logic [1:0]  w_vi, w_sv, w_ev;
    logic signed [gci_pkg::LEN_W-1:0] w_len;
    logic [gci_pkg::CNT_W-1:0] w_cnt;
    logic signed [gci_pkg::LEN_W:0] w_max;

    always_comb begin
        w_max = (gci_pkg::LEN_W+1)'(gci_pkg::MAX_SPAN);
        w_cmd = i_data[3:0];
        w_vi  = i_data[5:4];
        w_sv  = i_data[31:30];
        w_ev  = i_data[33:32];
        w_len = i_data[47:34];
        w_cnt = i_data[60:48];
        w_item.cmd     = w_cmd;
        w_item.load_ok = (w_vi != 2'd3);
        w_item.vi      = w_vi;
        w_item.r       = i_data[13:6];
        w_item.g       = i_data[21:14];
        w_item.b       = i_data[29:22];
        w_item.sv      = (w_sv == 2'd3) ? 2'd2 : w_sv;
        w_item.ev      = (w_ev == 2'd3) ? 2'd2 : w_ev;
        // clamp to +/- MAX_SPAN
        if ($signed({w_len[gci_pkg::LEN_W-1], w_len}) > w_max)
            w_item.len = w_max[gci_pkg::LEN_W-1:0];
        else if ($signed({w_len[gci_pkg::LEN_W-1], w_len}) < -w_max)
            w_item.len = gci_pkg::LEN_W'(-w_max);
        else
            w_item.len = w_len;
        if ({1'b0, w_cnt} > w_max)
            w_item.cnt = w_max[gci_pkg::CNT_W-1:0];
        else
            w_item.cnt = w_cnt;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready)
            r_q[r_wp] <= w_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wp <= ~r_wp;
            if (o_valid && i_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_valid && i_ready);
        end
    end
endmodule

>>> sv/gci_div.sv
// Radix-2 restoring signed divider, truncating toward zero.
`timescale 1ns / 1ps

module gci_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,
    input  logic [13:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [32:0] r_q;
    logic [13:0] r_rem;
    logic [12:0] r_den;
    logic        r_neg;
    logic [5:0]  r_n;
    logic        r_busy;
    logic [14:0] w_trial;
    logic [32:0] w_an;
    logic [13:0] w_ad;

    assign w_an    = i_num[32] ? -i_num : i_num;
    assign w_ad    = i_den[13] ? -i_den : i_den;
    assign w_trial = {r_rem, r_q[32]} - {2'b0, r_den};
    assign o_done  = r_busy && (r_n == 6'd0);
    assign o_quot  = r_neg ? 32'(-r_q) : r_q[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_n    <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_n    <= 6'd33;
            r_q    <= w_an;
            r_rem  <= 14'd0;
            r_den  <= w_ad[12:0];
            r_neg  <= i_num[32] ^ i_den[13];
        end else if (r_busy && r_n != 6'd0) begin
            // shift in one bit, subtract when it fits
            r_n <= r_n - 6'd1;
            if (!w_trial[14]) begin
                r_rem <= w_trial[13:0];
                r_q   <= {r_q[31:0], 1'b1};
            end else begin
                r_rem <= {r_rem[12:0], r_q[32]};
                r_q   <= {r_q[31:0], 1'b0};
            end
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end
endmodule

>>> sv/gci_back.sv
// Back end: color state, setup through the divider, stepping and shading.
`timescale 1ns / 1ps

module gci_back #(
    parameter int FRACTION_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  gci_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [23:0]    o_data
);
    gci_pkg::t_state r_st, n_st;
    gci_pkg::t_item  r_it;
    logic [31:0] r_vc [9];
    logic [31:0] r_lc [3], r_ld [3], r_rc [3], r_rd [3], r_sc [3], r_sd [3];
    logic [31:0] r_dq [3];
    logic [1:0]  r_k;
    logic [23:0] r_out;
    logic        r_ov;
    logic        r_divbusy;

    logic [32:0] w_num;
    logic [31:0] w_a, w_b, w_q;
    logic        w_start, w_done, w_div;
    logic [31:0] w_prod;
    logic [3:0]  w_ia, w_ib;

    // vertex index times three plus channel
    always_comb begin
        w_ia = 4'({2'b0, r_it.sv} * 4'd3) + 4'(r_k);
        w_ib = 4'({2'b0, r_it.ev} * 4'd3) + 4'(r_k);
        if (r_it.cmd == gci_pkg::CMD_SPAN_SETUP) begin
            w_a = r_lc[r_k];
            w_b = r_rc[r_k];
            w_div = (r_it.len > 0);
        end else begin
            w_a = r_vc[w_ia];
            w_b = r_vc[w_ib];
            w_div = (r_it.len != 0);
        end
        w_num = {w_b[31], w_b} - {w_a[31], w_a};
    end

    assign w_start = (r_st == gci_pkg::ST_DIV) && w_div && !w_done &&
                     !r_divbusy;

    gci_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_num(w_num),
        .i_den(r_it.len), .o_done(w_done), .o_quot(w_q)
    );

    logic [31:0] w_sel_d, w_sel_c;
    always_comb begin
        case (r_it.cmd)
            gci_pkg::CMD_STEP_SPAN: begin w_sel_c = r_sc[r_k]; w_sel_d = r_sd[r_k]; end
            gci_pkg::CMD_STEP_LEFT: begin w_sel_c = r_lc[r_k]; w_sel_d = r_ld[r_k]; end
            default:                begin w_sel_c = r_rc[r_k]; w_sel_d = r_rd[r_k]; end
        endcase
        w_prod = 32'(w_sel_d * {19'd0, r_it.cnt});
    end

    // shade one channel
    function automatic logic [7:0] shade(input logic [31:0] c, input logic [7:0] t);
        logic signed [31:0] ip;
        logic signed [41:0] p;
        begin
            ip = $signed(c) >>> FRACTION_BITS;
            p  = $signed(ip) * $signed({1'b0, t});
            if (p < 0) shade = 8'd0;
            else if ((p >>> 8) > 255) shade = 8'd255;
            else shade = p[15:8];
        end
    endfunction

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            gci_pkg::ST_IDLE: if (i_valid) begin
                unique case (i_item.cmd) inside
                    gci_pkg::CMD_LEFT_SETUP, gci_pkg::CMD_RIGHT_SETUP,
                    gci_pkg::CMD_SPAN_SETUP: n_st = gci_pkg::ST_DIV;
                    gci_pkg::CMD_STEP_SPAN, gci_pkg::CMD_STEP_LEFT,
                    gci_pkg::CMD_STEP_RIGHT: n_st = gci_pkg::ST_STEP;
                    gci_pkg::CMD_SHADE: n_st = gci_pkg::ST_OUT;
                    default: n_st = gci_pkg::ST_IDLE;
                endcase
            end
            gci_pkg::ST_DIV: if ((!w_div || w_done) && r_k == 2'd2) n_st = gci_pkg::ST_WRITE;
            gci_pkg::ST_WRITE: n_st = gci_pkg::ST_IDLE;
            gci_pkg::ST_STEP: if (r_k == 2'd2) n_st = gci_pkg::ST_IDLE;
            gci_pkg::ST_OUT: if (!r_ov || i_ready) n_st = gci_pkg::ST_IDLE;
            default: n_st = gci_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_st == gci_pkg::ST_IDLE);
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= gci_pkg::ST_IDLE;
            r_k  <= 2'd0;
            r_ov <= 1'b0;
            r_divbusy <= 1'b0;
            for (int i = 0; i < 9; i++) r_vc[i] <= '0;
            for (int i = 0; i < 3; i++) begin
                r_lc[i] <= '0; r_ld[i] <= '0; r_rc[i] <= '0;
                r_rd[i] <= '0; r_sc[i] <= '0; r_sd[i] <= '0;
            end
        end else begin
            r_st <= n_st;
            if (r_ov && i_ready) r_ov <= 1'b0;
            if (w_start) r_divbusy <= 1'b1;
            if (w_done)  r_divbusy <= 1'b0;
            unique case (r_st)
                gci_pkg::ST_IDLE: begin
                    r_k <= 2'd0;
                    if (i_valid) begin
                        r_it <= i_item;
                        if (i_item.cmd == gci_pkg::CMD_LOAD && i_item.load_ok) begin
                            r_vc[4'(i_item.vi) * 3]     <= 32'(i_item.r) << FRACTION_BITS;
                            r_vc[4'(i_item.vi) * 3 + 1] <= 32'(i_item.g) << FRACTION_BITS;
                            r_vc[4'(i_item.vi) * 3 + 2] <= 32'(i_item.b) << FRACTION_BITS;
                        end
                        if (i_item.cmd == gci_pkg::CMD_SWAP) begin
                            for (int i = 0; i < 3; i++) begin
                                r_lc[i] <= r_rc[i]; r_rc[i] <= r_lc[i];
                                r_ld[i] <= r_rd[i]; r_rd[i] <= r_ld[i];
                                r_vc[4'(i_item.sv) * 3 + i] <= r_vc[4'(i_item.ev) * 3 + i];
                                r_vc[4'(i_item.ev) * 3 + i] <= r_vc[4'(i_item.sv) * 3 + i];
                            end
                        end
                    end
                end
                gci_pkg::ST_DIV: begin
                    if (!w_div || w_done) begin
                        r_dq[r_k] <= w_div ? w_q : w_num[31:0];
                        r_k <= r_k + 2'd1;
                    end
                end
                gci_pkg::ST_WRITE: begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_it.cmd == gci_pkg::CMD_LEFT_SETUP) begin
                            r_lc[i] <= r_vc[4'(r_it.sv) * 3 + i]; r_ld[i] <= r_dq[i];
                        end else if (r_it.cmd == gci_pkg::CMD_RIGHT_SETUP) begin
                            r_rc[i] <= r_vc[4'(r_it.sv) * 3 + i]; r_rd[i] <= r_dq[i];
                        end else begin
                            r_sc[i] <= r_lc[i] + (32'd1 << (FRACTION_BITS - 1));
                            r_sd[i] <= r_dq[i];
                        end
                    end
                end
                gci_pkg::ST_STEP: begin
                    r_k <= r_k + 2'd1;
                    case (r_it.cmd)
                        gci_pkg::CMD_STEP_SPAN: r_sc[r_k] <= w_sel_c + w_prod;
                        gci_pkg::CMD_STEP_LEFT: r_lc[r_k] <= w_sel_c + w_prod;
                        default:                r_rc[r_k] <= w_sel_c + w_prod;
                    endcase
                end
                gci_pkg::ST_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_ov  <= 1'b1;
                        r_out <= {shade(r_sc[2], r_it.b), shade(r_sc[1], r_it.g),
                                  shade(r_sc[0], r_it.r)};
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

>>> sv/gouraud_color_interpolator.sv
// Top level of the Gouraud color interpolator.
// Load, swap act in the idle state; step and shade use their own states;
// setup runs each channel through the shared serial divider (one quotient
// bit per cycle). Back end: one command at a time; a two-entry queue
// decouples acceptance. Reset (synchronous, active low) zeros color state.
`timescale 1ns / 1ps

module gouraud_color_interpolator #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command, vertex_index, red, green, blue, start_vertex, end_vertex,
    // span_length, step_count
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0] m_axis_tdata
);
    logic           w_qv, w_qr;
    gci_pkg::t_item w_item;

    gci_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata[gci_pkg::IN_W-1:0]),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_item)
    );

    gci_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_item(w_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );
endmodule
